// ===== hdl/dls_pkg.sv =====
// ----------------------------------------------------------------------------
// Discrete Laplacian stream package
// Shared widths, the result burst type and a saturating helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dls_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned BURST_MAX = 4;
   localparam int unsigned COUNT_W   = 3;
   localparam logic [DATA_W-1:0] SCALE_RESET = 32'd16384;

   // Up to four result words that one sample releases, index 0 goes out first.
   typedef struct packed {
      logic [BURST_MAX-1:0][DATA_W-1:0] vals;
      logic [COUNT_W-1:0]               count;
      logic                             last;
   } dls_burst_type;

   // Linear extrapolation 2*a - b, clamped to the signed 32-bit range.
   function automatic logic [DATA_W-1:0] extrap_sat(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W+1:0] e;
      logic [DATA_W-1:0]        res;
      e = {{1{a[DATA_W-1]}}, a, 1'b0} - {{2{b[DATA_W-1]}}, b};
      if (e > 34'sh0_7FFF_FFFF) begin
         res = 32'h7FFF_FFFF;
      end else if (e < -34'sh0_8000_0000) begin
         res = 32'h8000_0000;
      end else begin
         res = e[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dls_burst_out.sv =====
// ----------------------------------------------------------------------------
// Result burst register
// Holds the result words of one sample and sends one per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_burst_out
   import dls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire dls_burst_type       burst,
   output logic                     load_ok,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DATA_W-1:0]        rsp_tdata,   // value[31:0]
   output logic                     rsp_tlast    // is_last_res
);

   logic [BURST_MAX-1:0][DATA_W-1:0] vals_ff;
   logic [COUNT_W-1:0]               rem_ff, rem_in;
   logic [1:0]                       idx_ff, idx_in;
   logic                             last_ff;
   logic                             take;

   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tdata  = vals_ff[idx_ff];
   assign rsp_tlast  = last_ff && (rem_ff == COUNT_W'(1));
   assign take       = rsp_tvalid && rsp_tready;

   // A new burst may load once the last word of the current one leaves.
   assign load_ok = (rem_ff == '0) || ((rem_ff == COUNT_W'(1)) && rsp_tready);

   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         rem_in = burst.count;
         idx_in = '0;
      end else if (take) begin
         rem_in = rem_ff - COUNT_W'(1);
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vals_ff <= burst.vals;
         last_ff <= burst.last;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/discrete_laplacian_stream_unit.sv =====
// Path: an accepted sample is registered in each pipeline stage, then in the burst register.
// Throughput: one sample per cycle while each sample releases at most one word and
//    rsp_tready is high; a two- to four-word sample holds stage 3 until its last word leaves.
// Output: one result word per cycle from the burst register while rsp_tready is high.
// Reset (synchronous, active high) empties the pipeline, clears the vector history
//    and sets the scale register to 0.25.
// ----------------------------------------------------------------------------
// Discrete Laplacian stream unit
// 1-D second difference, scaling with rounding, saturation and end extrapolation.
// ----------------------------------------------------------------------------
`default_nettype none

module discrete_laplacian_stream_unit
   import dls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [DATA_W-1:0]   csr_data,    // scale[31:0]
   // samples
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [DATA_W-1:0]   req_tdata,   // sample[31:0]
   input  wire logic                req_tlast,   // is_last
   // results
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DATA_W-1:0]        rsp_tdata,   // value[31:0]
   output logic                     rsp_tlast    // is_last_res
);

   logic [DATA_W-1:0] scale_ff;

   // vector history
   logic signed [DATA_W-1:0] older_ff, newer_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic signed [DATA_W-1:0] term_ff;

   // stage 1: second difference
   logic                     v1_ff;
   logic signed [DATA_W+2:0] d1_ff, d1_in;
   logic [COUNT_W-1:0]       cnt1_ff;
   logic                     last1_ff;

   // stage 2: partial products
   logic                     v2_ff;
   logic [DATA_W+1:0]        mag;
   logic [49:0]              phi2_ff, plo2_ff;
   logic                     neg2_ff;
   logic [COUNT_W-1:0]       cnt2_ff;
   logic                     last2_ff;

   // stage 3: saturated interior term
   logic                     v3_ff;
   logic [50:0]              rsum;
   logic signed [DATA_W-1:0] t3_ff, t3_in;
   logic [COUNT_W-1:0]       cnt3_ff;
   logic                     last3_ff;

   logic ready1, ready2, ready3;
   logic accept, adv2, adv3, load_ok;
   logic [DATA_W-1:0] ex_a, ex_b;
   dls_burst_type     burst;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         scale_ff <= csr_data;
      end
   end

   // Each stage moves on when the next one is empty or moving too.
   assign adv3   = v3_ff && load_ok;
   assign ready3 = !v3_ff || load_ok;
   assign adv2   = v2_ff && ready3;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_tready = ready1;
   assign accept = req_tvalid && ready1;

   assign d1_in = {{3{req_tdata[DATA_W-1]}}, req_tdata}
                - {{2{newer_ff[DATA_W-1]}}, newer_ff, 1'b0}
                + {{3{older_ff[DATA_W-1]}}, older_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            older_ff <= '0;
            newer_ff <= '0;
            count_ff <= '0;
         end else begin
            older_ff <= newer_ff;
            newer_ff <= req_tdata;
            if (count_ff < COUNT_W'(BURST_MAX)) begin
               count_ff <= count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_tvalid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d1_ff    <= d1_in;
         cnt1_ff  <= count_ff;
         last1_ff <= req_tlast;
      end
   end

   // The magnitude of the difference stays below 2^34.
   assign mag = d1_ff[DATA_W+2] ? (DATA_W+2)'(0) - d1_ff[DATA_W+1:0] : d1_ff[DATA_W+1:0];

   always_ff @(posedge clock) begin
      if (v1_ff && ready2) begin
         phi2_ff  <= 50'(mag) * 50'(scale_ff[31:16]);
         plo2_ff  <= 50'(mag) * 50'(scale_ff[15:0]);
         neg2_ff  <= d1_ff[DATA_W+2];
         cnt2_ff  <= cnt1_ff;
         last2_ff <= last1_ff;
      end
   end

   // Round half away from zero on the magnitude, then clamp with the sign applied.
   always_comb begin
      rsum = 51'(phi2_ff) + 51'((51'(plo2_ff) + 51'h8000) >> 16);
      if (!neg2_ff) begin
         t3_in = (rsum > 51'h7FFF_FFFF) ? 32'sh7FFF_FFFF : rsum[DATA_W-1:0];
      end else begin
         t3_in = (rsum > 51'h8000_0000) ? 32'sh8000_0000 : DATA_W'(0) - rsum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         t3_ff    <= t3_in;
         cnt3_ff  <= cnt2_ff;
         last3_ff <= last2_ff;
      end
   end

   // Newest interior term, held until a later sample releases it into a burst.
   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
      end else if (adv3) begin
         term_ff <= last3_ff ? '0 : t3_ff;
      end
   end

   assign ex_a = extrap_sat(term_ff, t3_ff);
   assign ex_b = extrap_sat(t3_ff, term_ff);

   always_comb begin
      burst       = '0;
      burst.last  = last3_ff;
      case (cnt3_ff)
         3'd0: begin
            if (last3_ff) burst.count = COUNT_W'(1);
         end
         3'd1: begin
            if (last3_ff) burst.count = COUNT_W'(2);
         end
         3'd2: begin
            if (last3_ff) begin
               burst.vals[0] = t3_ff;
               burst.vals[1] = t3_ff;
               burst.vals[2] = t3_ff;
               burst.count   = COUNT_W'(3);
            end
         end
         3'd3: begin
            // The first end value goes out ahead of the first interior term.
            burst.vals[0] = ex_a;
            burst.vals[1] = term_ff;
            burst.count   = COUNT_W'(2);
            if (last3_ff) begin
               burst.vals[2] = t3_ff;
               burst.vals[3] = ex_b;
               burst.count   = COUNT_W'(4);
            end
         end
         default: begin
            burst.vals[0] = term_ff;
            burst.count   = COUNT_W'(1);
            if (last3_ff) begin
               burst.vals[1] = t3_ff;
               burst.vals[2] = ex_b;
               burst.count   = COUNT_W'(3);
            end
         end
      endcase
   end

   dls_burst_out u_burst_out (
      .clock      (clock),
      .reset      (reset),
      .load       (adv3),
      .burst      (burst),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Discrete Laplacian stream unit testbench
// Streams sample vectors through the unit under several scale settings and
// compares every result word, value and last flag, with a behavioral
// predictor or with results typed into the directed table. A short table of
// directed vectors comes first, then random vectors. Both stream sides idle
// at random, and the receiver stalls once long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
   import dls_pkg::*;

   localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN = 32'h8000_0000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_ITEMS = 55;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
   } word_t;

   // A directed row either leaves its results to the predictor or types them
   // in: n result words, all equal to val, with the flag on the final one.
   typedef struct packed {
      logic [31:0] sample;
      logic        last;
      logic        typed;
      logic [2:0]  n;
      logic [31:0] val;
   } dir_row_t;

   localparam int NUM_DIRECTED = 25;
   localparam dir_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
      '{VAL_MAX,       1'b1, 1'b1, 3'd1, 32'd0},   // one-element vector
      '{VAL_MIN,       1'b0, 1'b1, 3'd0, 32'd0},   // two-element vector
      '{VAL_MAX,       1'b1, 1'b1, 3'd2, 32'd0},
      '{32'h0005_0000, 1'b0, 1'b1, 3'd0, 32'd0},   // flat three-element vector
      '{32'h0005_0000, 1'b0, 1'b1, 3'd0, 32'd0},
      '{32'h0005_0000, 1'b1, 1'b1, 3'd3, 32'd0},
      '{VAL_MAX,       1'b0, 1'b1, 3'd0, 32'd0},   // saturates high
      '{VAL_MIN,       1'b0, 1'b1, 3'd0, 32'd0},
      '{VAL_MAX,       1'b1, 1'b1, 3'd3, VAL_MAX},
      '{VAL_MIN,       1'b0, 1'b0, 3'd0, 32'd0},   // four elements, end saturation
      '{VAL_MAX,       1'b0, 1'b0, 3'd0, 32'd0},
      '{VAL_MIN,       1'b0, 1'b0, 3'd0, 32'd0},
      '{VAL_MAX,       1'b1, 1'b0, 3'd0, 32'd0},
      '{32'h0001_0000, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'hFFFF_0000, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h0000_0000, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h1234_5678, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h8000_0001, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h7FFF_FFFE, 1'b1, 1'b0, 3'd0, 32'd0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 3'd1, 32'd0},
      '{32'h0000_0001, 1'b0, 1'b0, 3'd0, 32'd0},   // rounding tie at a small size
      '{32'h0000_0003, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h0000_0007, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h0000_000F, 1'b0, 1'b0, 3'd0, 32'd0},
      '{32'h7FFF_0000, 1'b1, 1'b0, 3'd0, 32'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   // Typed expectations travel beside the word that is on offer.
   logic        offer_typed = 1'b0;
   logic [2:0]  offer_n = '0;
   logic [31:0] offer_val = '0;

   // Predictor state.
   logic [31:0] scale_reg;
   logic [31:0] hist_older;
   logic [31:0] hist_newer;
   int          hist_count;
   logic [31:0] term_newest;

   word_t expected_words[$];
   int    errors = 0;
   int    rsp_count = 0;
   int    quiet_cycles = 0;
   bit    calm = 1'b0;

   always #1 clock = ~clock;

   discrete_laplacian_stream_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic logic [31:0] clamp32(input longint v);
      if (v > SAT_HI) begin
         return VAL_MAX;
      end else if (v < SAT_LO) begin
         return VAL_MIN;
      end
      return v[31:0];
   endfunction

   // Second difference times the scale, rounded half away from zero.
   function automatic logic [31:0] scaled_diff(input logic [31:0] x0, input logic [31:0] x1,
                                               input logic [31:0] x2, input logic [31:0] s);
      longint d;
      longint m;
      longint r;
      d = longint'($signed(x2)) - 2 * longint'($signed(x1)) + longint'($signed(x0));
      m = (d < 0) ? -d : d;
      r = m * longint'(s[31:16]) + ((m * longint'(s[15:0]) + 32768) >>> 16);
      if (d < 0) begin
         r = -r;
      end
      return clamp32(r);
   endfunction

   function automatic logic [31:0] extrapolate(input logic [31:0] a, input logic [31:0] b);
      return clamp32(2 * longint'($signed(a)) - longint'($signed(b)));
   endfunction

   task automatic clear_history();
      hist_older = '0;
      hist_newer = '0;
      hist_count = 0;
      term_newest = '0;
   endtask

   // Advances the predictor by one sample and returns the words it releases.
   task automatic laplacian_step(input logic [31:0] sample, input logic last,
                                 output int n, output word_t res[4]);
      logic [31:0] t;
      n = 0;
      t = scaled_diff(hist_older, hist_newer, sample, scale_reg);
      case (hist_count)
         0: begin
            if (last) begin
               res[n] = '{32'd0, 1'b1}; n++;
            end
         end
         1: begin
            if (last) begin
               res[n] = '{32'd0, 1'b0}; n++;
               res[n] = '{32'd0, 1'b1}; n++;
            end
         end
         2: begin
            if (last) begin
               res[n] = '{t, 1'b0}; n++;
               res[n] = '{t, 1'b0}; n++;
               res[n] = '{t, 1'b1}; n++;
            end else begin
               term_newest = t;
            end
         end
         3: begin
            res[n] = '{extrapolate(term_newest, t), 1'b0}; n++;
            res[n] = '{term_newest, 1'b0}; n++;
            if (last) begin
               res[n] = '{t, 1'b0}; n++;
               res[n] = '{extrapolate(t, term_newest), 1'b1}; n++;
            end
            term_newest = t;
         end
         default: begin
            res[n] = '{term_newest, 1'b0}; n++;
            if (last) begin
               res[n] = '{t, 1'b0}; n++;
               res[n] = '{extrapolate(t, term_newest), 1'b1}; n++;
            end
            term_newest = t;
         end
      endcase
      if (last) begin
         clear_history();
      end else begin
         hist_older = hist_newer;
         hist_newer = sample;
         if (hist_count < 4) begin
            hist_count++;
         end
      end
   endtask

   // Predicts on every accepted sample and checks every accepted result word.
   always @(posedge clock) begin : watch
      word_t res[4];
      word_t exp_w;
      int    n;
      bit    moved;
      if (reset) begin
         scale_reg = SCALE_RESET;
         clear_history();
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            scale_reg = csr_data;
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            laplacian_step(req_tdata, req_tlast, n, res);
            if (offer_typed) begin
               n = offer_n;
               for (int i = 0; i < n; i++) begin
                  res[i] = '{offer_val, i == n - 1};
               end
            end
            for (int i = 0; i < n; i++) begin
               expected_words = {expected_words, res[i]};
            end
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            moved = 1'b1;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_tdata !== exp_w.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, exp_w.value, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== exp_w.last) begin
                  $display("%0t: last flag mismatch, expected %b, actual %b",
                           $time, exp_w.last, rsp_tlast);
                  errors++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off, no stalls at the end.
   initial begin : receiver
      bit held_off;
      held_off = 1'b0;
      @(negedge reset);
      forever begin
         if (!held_off && rsp_count >= 40) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_sample();
      logic [31:0] mag;
      mag = $urandom_range(0, 32'h0003_FFFF);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6: return $urandom_range(0, 1) ? -mag : mag;
         7: begin
            case ($urandom_range(0, 3))
               0: return VAL_MAX;
               1: return VAL_MIN;
               2: return 32'd0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic send_sample(input logic [31:0] s, input logic l, input logic typed,
                              input logic [2:0] n, input logic [31:0] v);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      req_tlast <= l;
      offer_typed <= typed;
      offer_n <= n;
      offer_val <= v;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_scale(input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Waits for every outstanding word, then lets the pipeline run dry.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : sender
      logic [31:0] phase_scales[NUM_PHASES];
      int sent;
      int len;
      phase_scales[0] = 32'h0000_0000;
      phase_scales[1] = 32'hFFFF_FFFF;
      phase_scales[2] = 32'h0001_0000;
      phase_scales[3] = $urandom;
      phase_scales[4] = $urandom_range(0, 32'h0004_0000);
      phase_scales[5] = $urandom_range(0, 32'h0002_0000);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The directed table runs at the reset scale of one quarter.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_sample(DIRECTED[i].sample, DIRECTED[i].last, DIRECTED[i].typed,
                     DIRECTED[i].n, DIRECTED[i].val);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_scale(phase_scales[p]);
         if (p == NUM_PHASES - 1) begin
            calm = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
               send_sample(pick_sample(), j == len - 1, 1'b0, 3'd0, 32'd0);
            end
            sent += len;
         end
      end
      settle();
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
